@@ hdl/semtab_pkg.sv @@
// shared types and constants of the semaphore table
package semtab_pkg;

   localparam int NUM_SEMAPHORES_DEF = 8;
   localparam int NUM_PROCESSES_DEF  = 16;

   localparam int PID_W   = 4;
   localparam int KEY_W   = 15;
   localparam int COUNT_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      FUNC_OPEN  = 2'd0,
      FUNC_CLOSE = 2'd1,
      FUNC_WAIT  = 2'd2,
      FUNC_POST  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVAL   = 2'd1,
      ST_FULL    = 2'd2,
      ST_BLOCKED = 2'd3
   } status_type;

   typedef struct packed {
      func_type           func;
      logic [PID_W-1:0]   caller_pid;
      logic signed [15:0] sem_key;
      logic signed [15:0] initial_count;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [KEY_W-1:0]   ret_value;
      logic               woke_valid;
      logic [PID_W-1:0]   woke_pid;
   } rsp_type;

endpackage

@@ hdl/semtab_waitq.sv @@
// waiter fifo storage, one ring of slots per table entry
module semtab_waitq import semtab_pkg::*; #(
   parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
   parameter int NUM_PROCESSES  = NUM_PROCESSES_DEF,
   localparam int DEPTH  = NUM_SEMAPHORES * NUM_PROCESSES,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [PID_W-1:0]  wr_pid,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [PID_W-1:0]  rd_pid
);

   logic [PID_W-1:0] mem [DEPTH];
   logic [PID_W-1:0] rd_pid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_pid;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_pid_ff <= mem[rd_addr];
      end
   end

   assign rd_pid = rd_pid_ff;

endmodule

@@ hdl/semtab_table.sv @@
// semaphore entry registers, key lookup and per-transaction update
module semtab_table import semtab_pkg::*; #(
   parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
   parameter int NUM_PROCESSES  = NUM_PROCESSES_DEF,
   localparam int DEPTH  = NUM_SEMAPHORES * NUM_PROCESSES,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  req_type           item,
   output logic              early_valid,
   output rsp_type           early,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [PID_W-1:0]  wr_pid,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr
);

   localparam int IDX_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
   localparam int PTR_W = $clog2(NUM_PROCESSES);
   localparam int TOT_W = $clog2(NUM_PROCESSES + 1);

   logic [NUM_SEMAPHORES-1:0] valid_ff;
   logic [KEY_W-1:0]          key_ff   [NUM_SEMAPHORES];
   logic [COUNT_W-1:0]        count_ff [NUM_SEMAPHORES];
   logic [NUM_PROCESSES-1:0]  mask_ff  [NUM_SEMAPHORES];
   logic [PTR_W-1:0]          head_ff  [NUM_SEMAPHORES];
   logic [PTR_W-1:0]          tail_ff  [NUM_SEMAPHORES];
   logic [TOT_W-1:0]          total_ff [NUM_SEMAPHORES];

   logic                     key_neg, init_neg, pid_ok;
   logic [KEY_W-1:0]         key;
   logic [NUM_PROCESSES-1:0] pid_bit;
   logic                     hit_any, free_any;
   logic [IDX_W-1:0]         hit_idx, free_idx, tgt;
   logic                     valid_sel;
   logic [COUNT_W-1:0]       count_sel;
   logic [NUM_PROCESSES-1:0] mask_sel;
   logic [PTR_W-1:0]         head_sel, tail_sel;
   logic [TOT_W-1:0]         total_sel;
   logic [ADDR_W-1:0]        base;

   logic                     upd;
   logic                     valid_in;
   logic [KEY_W-1:0]         key_in;
   logic [COUNT_W-1:0]       count_in;
   logic [NUM_PROCESSES-1:0] mask_in;
   logic [PTR_W-1:0]         head_in, tail_in;
   logic [TOT_W-1:0]         total_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(NUM_PROCESSES - 1)) ? '0 : p + 1'b1;
   endfunction

   assign key_neg  = item.sem_key[15];
   assign init_neg = item.initial_count[15];
   assign key      = item.sem_key[KEY_W-1:0];
   assign pid_ok   = (int'(item.caller_pid) < NUM_PROCESSES);
   assign pid_bit  = {{(NUM_PROCESSES-1){1'b0}}, 1'b1} << item.caller_pid;

   // key match, at most one entry hits
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < NUM_SEMAPHORES; i++) begin
         if (valid_ff[i] && (key_ff[i] == key)) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   // lowest free entry
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = NUM_SEMAPHORES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign tgt       = hit_any ? hit_idx : free_idx;
   assign valid_sel = valid_ff[tgt];
   assign count_sel = count_ff[tgt];
   assign mask_sel  = mask_ff[tgt];
   assign head_sel  = head_ff[tgt];
   assign tail_sel  = tail_ff[tgt];
   assign total_sel = total_ff[tgt];
   assign base      = ADDR_W'(tgt) * ADDR_W'(NUM_PROCESSES);

   assign wr_addr     = base + ADDR_W'(tail_sel);
   assign rd_addr     = base + ADDR_W'(head_sel);
   assign wr_pid      = item.caller_pid;
   assign early_valid = item_valid;

   always_comb begin
      upd      = 1'b0;
      valid_in = valid_sel;
      key_in   = key_ff[tgt];
      count_in = count_sel;
      mask_in  = mask_sel;
      head_in  = head_sel;
      tail_in  = tail_sel;
      total_in = total_sel;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      early    = '{status: ST_INVAL, ret_value: '0, woke_valid: 1'b0, woke_pid: '0};
      if (item_valid && !key_neg && pid_ok) begin
         case (item.func)
            FUNC_OPEN: begin
               if (!init_neg) begin
                  if (hit_any) begin
                     upd             = 1'b1;
                     mask_in         = mask_sel | pid_bit;
                     early.status    = ST_OK;
                     early.ret_value = key;
                  end else if (free_any) begin
                     // allocate a fresh entry
                     upd             = 1'b1;
                     valid_in        = 1'b1;
                     key_in          = key;
                     count_in        = $unsigned(item.initial_count);
                     mask_in         = pid_bit;
                     head_in         = '0;
                     tail_in         = '0;
                     total_in        = '0;
                     early.status    = ST_OK;
                     early.ret_value = key;
                  end else begin
                     early.status = ST_FULL;
                  end
               end
            end
            default: begin
               if (hit_any && ((mask_sel & pid_bit) != '0)) begin
                  case (item.func)
                     FUNC_CLOSE: begin
                        upd     = 1'b1;
                        mask_in = mask_sel & ~pid_bit;
                        if ((mask_in == '0) && (total_sel == '0)) begin
                           valid_in = 1'b0;
                        end
                        early.status = ST_OK;
                     end
                     FUNC_WAIT: begin
                        if (count_sel != '0) begin
                           upd          = 1'b1;
                           count_in     = count_sel - 1'b1;
                           early.status = ST_OK;
                        end else if (total_sel == TOT_W'(NUM_PROCESSES)) begin
                           early.status = ST_FULL;
                        end else begin
                           upd          = 1'b1;
                           wr_en        = 1'b1;
                           tail_in      = ptr_next(tail_sel);
                           total_in     = total_sel + 1'b1;
                           early.status = ST_BLOCKED;
                        end
                     end
                     FUNC_POST: begin
                        if (total_sel != '0) begin
                           upd              = 1'b1;
                           rd_en            = 1'b1;
                           head_in          = ptr_next(head_sel);
                           total_in         = total_sel - 1'b1;
                           early.woke_valid = 1'b1;
                        end else if (count_sel != COUNT_MAX) begin
                           upd      = 1'b1;
                           count_in = count_sel + 1'b1;
                        end
                        early.status = ST_OK;
                     end
                     default: begin
                        early.status = ST_INVAL;
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            mask_ff[i]  <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            total_ff[i] <= '0;
         end
      end else if (upd) begin
         valid_ff[tgt] <= valid_in;
         mask_ff[tgt]  <= mask_in;
         head_ff[tgt]  <= head_in;
         tail_ff[tgt]  <= tail_in;
         total_ff[tgt] <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         key_ff[tgt]   <= key_in;
         count_ff[tgt] <= count_in;
      end
   end

   // an entry with queued waiters is never freed
   a_waiters_keep_entry: assert property (@(posedge clock) disable iff (reset)
      (total_sel != '0) |-> valid_sel)
      else $error("entry with waiters is not valid");

   // empty or full ring has head and tail together
   a_ring_pointers: assert property (@(posedge clock) disable iff (reset)
      ((total_sel == '0) || (total_sel == TOT_W'(NUM_PROCESSES))) |-> (head_sel == tail_sel))
      else $error("waiter ring pointers out of step with fill");

endmodule

@@ hdl/semtab_resp.sv @@
// result register, merges the woken process number from the waiter storage
module semtab_resp import semtab_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             early_valid,
   input  rsp_type          early,
   input  logic [PID_W-1:0] rd_pid,
   output logic             rsp_strobe,
   output rsp_type          rsp_item
);

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= early_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (early_valid) begin
         rsp_ff <= early;
      end
   end

   always_comb begin
      rsp_item          = rsp_ff;
      rsp_item.woke_pid = rsp_ff.woke_valid ? rd_pid : '0;
   end

   assign rsp_strobe = rsp_valid_ff;

   a_woke_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.woke_valid) |-> (rsp_ff.status == ST_OK))
      else $error("woken process reported with non-ok status");

endmodule

@@ hdl/counting_semaphore_table.sv @@
// top level of the counting semaphore table
//
// user notes: the block keeps a table of counting semaphores addressed by a
// 15-bit key, each with a count, a mask of opener processes and a ring of
// waiting process numbers. one transaction (open, close, wait or post) is
// taken per clock whenever start is high and busy is low; busy is high only
// while reset is held and until its register next samples reset low. every
// transaction gives exactly one result, in order: the transaction is
// registered, the key compare over all entries and the update of the one
// selected entry happen in the next cycle, and the result leaves from the
// output register with rsp_strobe high for a single cycle. the receiver
// cannot stall, and none is needed, since the output register is refilled
// at the same rate as transactions arrive. a post that releases a waiter
// reads the waiter ring memory in the update cycle; its registered read data
// is the woken process number shown with the result. sustained rate is one
// transaction per clock while busy is low, since the key compare, the entry
// update and the one read or write of the waiter memory all take place in
// the same cycle. the entry table needs no clearing pass after reset: valid
// bits, opener masks and ring pointers reset at once.
module counting_semaphore_table import semtab_pkg::*; #(
   parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
   parameter int NUM_PROCESSES  = NUM_PROCESSES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int DEPTH  = NUM_SEMAPHORES * NUM_PROCESSES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic    busy_ff;
   logic    accept;
   logic    item_valid_ff;
   req_type item_ff;

   logic              early_valid;
   rsp_type           early;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [PID_W-1:0]  wr_pid, rd_pid;

   // held busy only around reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   // lookup and single-entry update
   semtab_table #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES),
      .NUM_PROCESSES  (NUM_PROCESSES)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid_ff),
      .item        (item_ff),
      .early_valid (early_valid),
      .early       (early),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_pid      (wr_pid),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   // waiter rings, read data lands with the result register
   semtab_waitq #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES),
      .NUM_PROCESSES  (NUM_PROCESSES)
   ) u_waitq (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_pid  (wr_pid),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_pid  (rd_pid)
   );

   // output register
   semtab_resp u_resp (
      .clock       (clock),
      .reset       (reset),
      .early_valid (early_valid),
      .early       (early),
      .rd_pid      (rd_pid),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   // every transaction gives one result, through the input and output registers
   a_one_result_per_transaction: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(accept, 2))
      else $error("result strobe does not match accepted transaction");

endmodule
